/* rtl/fdtd_1d_leapfrog_step_core_defines.svh */
// ----------------------------------------------------------------------------
// fdtd_1d_leapfrog_step_core_defines
// assertion macros shared by the grid engine; they use clk_i and rst_ni
// ----------------------------------------------------------------------------
`ifndef FDTD_1D_LEAPFROG_STEP_CORE_DEFINES_SVH
`define FDTD_1D_LEAPFROG_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define FD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fdtd1d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd1d_pkg
// widths, codes and saturation helper of the 1-d leapfrog grid engine
// ----------------------------------------------------------------------------
package fdtd1d_pkg;

  localparam int unsigned FIELD_W    = 32;  // q16.16
  localparam int unsigned COEF_W     = 32;  // q10.22
  localparam int unsigned FRAC_BITS  = 22;
  localparam int unsigned PROD_W     = FIELD_W + COEF_W;
  localparam int unsigned RND_W      = PROD_W - FRAC_BITS;
  localparam int unsigned SUM_W      = RND_W + 1;
  localparam int unsigned ACTIVE_W   = 11;
  localparam int unsigned NODE_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [ACTIVE_W-1:0] RST_ACTIVE     = 11'd1024;
  localparam logic [NODE_W-1:0]   RST_SRC_NODE_H = 10'd0;
  localparam logic [NODE_W-1:0]   RST_SRC_NODE_E = 10'd1;

  localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  localparam logic BND_PEC = 1'b0;
  localparam logic BND_ABC = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_STEP = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SEL_H_SELF = 2'd0,
    SEL_H_CURL = 2'd1,
    SEL_E_SELF = 2'd2,
    SEL_E_CURL = 2'd3
  } coef_sel_e;

  typedef enum logic [1:0] {
    SRC_HARD = 2'd0,
    SRC_ADD  = 2'd1,
    SRC_SUB  = 2'd2,
    SRC_OFF  = 2'd3
  } src_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_NODES  = 3'd0,
    CFG_BOUNDARY_MODE = 3'd1,
    CFG_SRC_MODE_H    = 3'd2,
    CFG_SRC_NODE_H    = 3'd3,
    CFG_SRC_MODE_E    = 3'd4,
    CFG_SRC_NODE_E    = 3'd5
  } cfg_idx_e;

  // operands handed to the shared multiplier
  typedef struct packed {
    logic signed [FIELD_W-1:0] field;
    logic signed [COEF_W-1:0]  coef;
  } mul_req_t;

  typedef struct packed {
    logic                      sat;
    logic signed [FIELD_W-1:0] val;
  } sat_t;

  // clamp a wide signed sum to the field range and flag the clamp
  function automatic sat_t sat_field(input logic signed [SUM_W-1:0] v);
    sat_t r;
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[SUM_W-1:FIELD_W-1];
    hi_zeros = ~|v[SUM_W-1:FIELD_W-1];
    r.sat    = !(hi_ones || hi_zeros);
    if (r.sat) begin
      r.val = v[SUM_W-1] ? FIELD_MIN : FIELD_MAX;
    end else begin
      r.val = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/fdtd1d_mulrnd.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd1d_mulrnd
// shared field by coefficient multiplier, registered product, then
// round to nearest (halves up) to q26.16 in the following cycle
// ----------------------------------------------------------------------------
module fdtd1d_mulrnd
  import fdtd1d_pkg::*;
(
  input  logic                    clk_i,
  input  mul_req_t                req_i,
  output logic signed [RND_W-1:0] rnd_o
);

  logic signed [FIELD_W-1:0] op_a;
  logic signed [COEF_W-1:0]  op_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  biased;

  assign op_a   = req_i.field;
  assign op_b   = req_i.coef;
  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // floor((p + half) / 2^frac) is the arithmetic shift of the biased product
  assign biased = prod_q + (PROD_W'(1) << (FRAC_BITS - 1));
  assign rnd_o  = biased[PROD_W-1:FRAC_BITS];

endmodule

/* rtl/fdtd_1d_leapfrog_step_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_1d_leapfrog_step_core
// one-dimensional yee leapfrog grid engine: coefficient load, time step
// and node read over on-chip e, h and coefficient memories
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   start / busy              action_i node_i coef_select_i coef_value_i
//                                      source_h_value_i source_e_value_i
//  result    done_o (one-cycle strobe) e_value_o h_value_o status_o
//  config    cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
//  after reset a clearing pass zeroes every node of the e and h memories
//  with busy high; config writes are taken throughout.
//  load and no-op requests pass through S_LOAD before done_o, reads through S_RD_A and S_RD_B.
//  a time step updates the e boundaries, then runs an h pass and an e pass over the
//  clamped active node count, each after its source injection, on the single multiplier.
//  the result strobe cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`include "fdtd_1d_leapfrog_step_core_defines.svh"

module fdtd_1d_leapfrog_step_core
  import fdtd1d_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action_i,
  input  logic [NODE_W-1:0]            node_i,
  input  logic [1:0]                   coef_select_i,
  input  logic signed [COEF_W-1:0]     coef_value_i,
  input  logic signed [FIELD_W-1:0]    source_h_value_i,
  input  logic signed [FIELD_W-1:0]    source_e_value_i,
  output logic                         done_o,
  output logic signed [FIELD_W-1:0]    e_value_o,
  output logic signed [FIELD_W-1:0]    h_value_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned CW = ($clog2(MAX_NODES + 1) > ACTIVE_W) ?
                               $clog2(MAX_NODES + 1) : ACTIVE_W;
  localparam logic [CW-1:0] N_MIN     = CW'(4);
  localparam logic [CW-1:0] N_MAX     = CW'(MAX_NODES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

  typedef enum logic [12:0] {
    S_CLEAR = 13'h0001,
    S_IDLE  = 13'h0002,
    S_LOAD  = 13'h0004,
    S_RD_A  = 13'h0008,
    S_RD_B  = 13'h0010,
    S_BND_A = 13'h0020,
    S_BND_B = 13'h0040,
    S_BND_C = 13'h0080,
    S_INJ_A = 13'h0100,
    S_INJ_B = 13'h0200,
    S_PASS  = 13'h0400,
    S_DRAIN = 13'h0800,
    S_FIN   = 13'h1000
  } state_e;

  // configuration registers
  logic [ACTIVE_W-1:0] active_q;
  logic                bnd_q;
  src_mode_e           smode_h_q;
  logic [NODE_W-1:0]   snode_h_q;
  src_mode_e           smode_e_q;
  logic [NODE_W-1:0]   snode_e_q;

  // captured request
  action_e                   act_q;
  logic [NODE_W-1:0]         node_q;
  coef_sel_e                 sel_q;
  logic signed [COEF_W-1:0]  coef_q;
  logic signed [FIELD_W-1:0] srch_q;
  logic signed [FIELD_W-1:0] srce_q;

  // sequencer
  state_e          state_q, state_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic            phase_q, phase_d;
  logic            pass_e_q, pass_e_d;
  logic            sat_q, sat_d;
  logic [3:0]      pv_q;
  logic [AW-1:0]   wa_q [4];
  logic            capture;
  logic            issue;

  // datapath registers
  logic signed [FIELD_W-1:0] prev_q;
  logic signed [FIELD_W-1:0] curl_q;
  logic signed [COEF_W-1:0]  c2_q;
  logic signed [RND_W-1:0]   r1_q;
  logic signed [RND_W-1:0]   r2_q;

  // result registers
  logic                      done_q, done_d;
  logic signed [FIELD_W-1:0] ev_q, ev_d;
  logic signed [FIELD_W-1:0] hv_q, hv_d;
  status_e                   status_q, status_d;

  // memories
  logic signed [FIELD_W-1:0] e_mem  [MAX_NODES];
  logic signed [FIELD_W-1:0] h_mem  [MAX_NODES];
  logic signed [COEF_W-1:0]  hs_mem [MAX_NODES];
  logic signed [COEF_W-1:0]  hc_mem [MAX_NODES];
  logic signed [COEF_W-1:0]  es_mem [MAX_NODES];
  logic signed [COEF_W-1:0]  ec_mem [MAX_NODES];

  logic                      e_we, h_we;
  logic [AW-1:0]             e_waddr, h_waddr, e_raddr, h_raddr;
  logic signed [FIELD_W-1:0] e_wdata, h_wdata;
  logic signed [FIELD_W-1:0] e_rd_q, h_rd_q;
  logic signed [COEF_W-1:0]  hs_rd_q, hc_rd_q, es_rd_q, ec_rd_q;
  logic                      coef_wr;

  // node count and range checks
  logic [CW-1:0] active_ext, n_cnt, n_m1;
  logic [AW-1:0] n_m1_addr, n_m2_addr, node_addr;
  logic          node_in_rng, node_has_h, h_src_ok, e_src_ok;

  // arithmetic
  logic signed [FIELD_W-1:0] field_rd, nbr_rd, inj_src, inj_val;
  logic signed [COEF_W-1:0]  self_rd, cc_rd;
  logic signed [FIELD_W:0]   curl_diff, inj_sum;
  logic signed [SUM_W-1:0]   upd_sum;
  sat_t                      curl_s, inj_s, sum_s;
  src_mode_e                 inj_mode;
  logic                      inj_wr, inj_sat_set, curl_sat_set, sum_sat_set;
  mul_req_t                  mul_req;
  logic signed [RND_W-1:0]   mul_rnd;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign e_value_o   = ev_q;
  assign h_value_o   = hv_q;
  assign status_o    = status_q;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= RST_ACTIVE;
      bnd_q     <= BND_PEC;
      smode_h_q <= SRC_ADD;
      snode_h_q <= RST_SRC_NODE_H;
      smode_e_q <= SRC_ADD;
      snode_e_q <= RST_SRC_NODE_E;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ACTIVE_NODES:  active_q  <= cfg_data_i[ACTIVE_W-1:0];
        CFG_BOUNDARY_MODE: bnd_q     <= cfg_data_i[0];
        CFG_SRC_MODE_H:    smode_h_q <= src_mode_e'(cfg_data_i[1:0]);
        CFG_SRC_NODE_H:    snode_h_q <= cfg_data_i[NODE_W-1:0];
        CFG_SRC_MODE_E:    smode_e_q <= src_mode_e'(cfg_data_i[1:0]);
        CFG_SRC_NODE_E:    snode_e_q <= cfg_data_i[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    active_ext = CW'(active_q);
    if (active_ext < N_MIN) begin
      n_cnt = N_MIN;
    end else if (active_ext > N_MAX) begin
      n_cnt = N_MAX;
    end else begin
      n_cnt = active_ext;
    end
  end

  assign n_m1        = n_cnt - CW'(1);
  assign n_m1_addr   = AW'(n_m1);
  assign n_m2_addr   = AW'(n_cnt - CW'(2));
  assign node_addr   = AW'(node_q);
  assign node_in_rng = CW'(node_q) < n_cnt;
  assign node_has_h  = CW'(node_q) < n_m1;
  assign h_src_ok    = (CW'(snode_h_q) < n_m1) && (smode_h_q != SRC_OFF);
  assign e_src_ok    = (CW'(snode_e_q) < n_cnt) && (smode_e_q != SRC_OFF);

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  // own array of the current pass, and the one whose curl drives it
  assign field_rd = pass_e_q ? e_rd_q : h_rd_q;
  assign nbr_rd   = pass_e_q ? h_rd_q : e_rd_q;
  assign self_rd  = pass_e_q ? es_rd_q : hs_rd_q;
  assign cc_rd    = pass_e_q ? ec_rd_q : hc_rd_q;

  assign curl_diff = (FIELD_W + 1)'(nbr_rd) - (FIELD_W + 1)'(prev_q);
  assign curl_s    = sat_field(SUM_W'(curl_diff));

  assign inj_mode = pass_e_q ? smode_e_q : smode_h_q;
  assign inj_src  = pass_e_q ? srce_q : srch_q;
  assign inj_sum  = (inj_mode == SRC_SUB) ?
                    (FIELD_W + 1)'(field_rd) - (FIELD_W + 1)'(inj_src) :
                    (FIELD_W + 1)'(field_rd) + (FIELD_W + 1)'(inj_src);
  assign inj_s    = sat_field(SUM_W'(inj_sum));
  assign inj_val  = (inj_mode == SRC_HARD) ? inj_src : inj_s.val;
  assign inj_wr   = (state_q == S_INJ_B) && (pass_e_q ? e_src_ok : h_src_ok);

  assign upd_sum  = SUM_W'(r1_q) + SUM_W'(r2_q);
  assign sum_s    = sat_field(upd_sum);

  assign inj_sat_set  = inj_wr && (inj_mode != SRC_HARD) && inj_s.sat;
  assign curl_sat_set = pv_q[0] && curl_s.sat;
  assign sum_sat_set  = pv_q[3] && sum_s.sat;

  // self term in a node's first multiplier slot, curl term in its second
  always_comb begin
    mul_req.field = pv_q[0] ? field_rd : curl_q;
    mul_req.coef  = pv_q[0] ? self_rd : c2_q;
  end

  fdtd1d_mulrnd u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .rnd_o (mul_rnd)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign issue = (state_q == S_PASS) && !phase_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    phase_d  = phase_q;
    pass_e_d = pass_e_q;
    sat_d    = sat_q;
    done_d   = 1'b0;
    ev_d     = '0;
    hv_d     = '0;
    status_d = ST_OK;
    capture  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        if (idx_q == LAST_ADDR) begin
          state_d = S_IDLE;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          capture  = 1'b1;
          sat_d    = 1'b0;
          pass_e_d = 1'b0;
          case (action_e'(action_i))
            ACT_STEP: state_d = S_BND_A;
            ACT_READ: state_d = S_RD_A;
            default:  state_d = S_LOAD;
          endcase
        end
      end
      S_LOAD: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if ((act_q == ACT_LOAD) && !node_in_rng) begin
          status_d = ST_RANGE;
        end
      end
      S_RD_A: state_d = S_RD_B;
      S_RD_B: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (node_in_rng) begin
          ev_d = e_rd_q;
          hv_d = node_has_h ? h_rd_q : '0;
        end else begin
          status_d = ST_RANGE;
        end
      end
      S_BND_A: state_d = S_BND_B;
      S_BND_B: state_d = S_BND_C;
      S_BND_C: state_d = S_INJ_A;
      S_INJ_A: state_d = S_INJ_B;
      S_INJ_B: begin
        state_d = S_PASS;
        phase_d = 1'b0;
        idx_d   = pass_e_q ? AW'(1) : '0;
      end
      S_PASS: begin
        phase_d = !phase_q;
        if (issue) begin
          if (idx_q == n_m2_addr) begin
            state_d = S_DRAIN;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        // last node alone in its write slot
        if (pv_q == 4'b1000) begin
          if (pass_e_q) begin
            state_d = S_FIN;
          end else begin
            state_d  = S_INJ_A;
            pass_e_d = 1'b1;
          end
        end
      end
      S_FIN: begin
        state_d  = S_IDLE;
        done_d   = 1'b1;
        status_d = sat_q ? ST_SAT : ST_OK;
      end
      default: state_d = S_IDLE;
    endcase
    if (inj_sat_set || curl_sat_set || sum_sat_set) begin
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      idx_q    <= '0;
      phase_q  <= 1'b0;
      pass_e_q <= 1'b0;
      sat_q    <= 1'b0;
      pv_q     <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      phase_q  <= phase_d;
      pass_e_q <= pass_e_d;
      sat_q    <= sat_d;
      pv_q     <= {pv_q[2:0], issue};
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      act_q  <= action_e'(action_i);
      node_q <= node_i;
      sel_q  <= coef_sel_e'(coef_select_i);
      coef_q <= coef_value_i;
      srch_q <= source_h_value_i;
      srce_q <= source_e_value_i;
    end
    if (pv_q[0]) begin
      curl_q <= curl_s.val;
      c2_q   <= cc_rd;
    end
    if (pv_q[0] || (state_q == S_INJ_B)) begin
      prev_q <= nbr_rd;
    end
    if (pv_q[1]) begin
      r1_q <= mul_rnd;
    end
    if (pv_q[2]) begin
      r2_q <= mul_rnd;
    end
    wa_q[0] <= idx_q;
    wa_q[1] <= wa_q[0];
    wa_q[2] <= wa_q[1];
    wa_q[3] <= wa_q[2];
    if (done_d) begin
      ev_q     <= ev_d;
      hv_q     <= hv_d;
      status_q <= status_d;
    end
  end

  // --------------------------------------------------------------------------
  // memory ports
  // --------------------------------------------------------------------------
  always_comb begin
    e_we    = 1'b0;
    e_waddr = wa_q[3];
    e_wdata = sum_s.val;
    if (state_q == S_CLEAR) begin
      e_we    = 1'b1;
      e_waddr = idx_q;
      e_wdata = '0;
    end else if (state_q == S_BND_B) begin
      e_we    = 1'b1;
      e_waddr = '0;
      e_wdata = (bnd_q == BND_ABC) ? e_rd_q : '0;
    end else if (state_q == S_BND_C) begin
      e_we    = 1'b1;
      e_waddr = n_m1_addr;
      e_wdata = (bnd_q == BND_ABC) ? e_rd_q : '0;
    end else if (inj_wr && pass_e_q) begin
      e_we    = 1'b1;
      e_waddr = AW'(snode_e_q);
      e_wdata = inj_val;
    end else if (pv_q[3] && pass_e_q) begin
      e_we    = 1'b1;
    end
  end

  always_comb begin
    h_we    = 1'b0;
    h_waddr = wa_q[3];
    h_wdata = sum_s.val;
    if (state_q == S_CLEAR) begin
      h_we    = 1'b1;
      h_waddr = idx_q;
      h_wdata = '0;
    end else if (inj_wr && !pass_e_q) begin
      h_we    = 1'b1;
      h_waddr = AW'(snode_h_q);
      h_wdata = inj_val;
    end else if (pv_q[3] && !pass_e_q) begin
      h_we    = 1'b1;
    end
  end

  always_comb begin
    e_raddr = pass_e_q ? idx_q : idx_q + 1'b1;
    h_raddr = idx_q;
    case (state_q)
      S_RD_A: begin
        e_raddr = node_addr;
        h_raddr = node_addr;
      end
      S_BND_A: e_raddr = AW'(1);
      S_BND_B: e_raddr = n_m2_addr;
      S_INJ_A: begin
        e_raddr = pass_e_q ? AW'(snode_e_q) : '0;
        h_raddr = pass_e_q ? '0 : AW'(snode_h_q);
      end
      default: ;
    endcase
  end

  assign coef_wr = (state_q == S_LOAD) && (act_q == ACT_LOAD) && node_in_rng;

  always_ff @(posedge clk_i) begin
    if (e_we) begin
      e_mem[e_waddr] <= e_wdata;
    end
    e_rd_q <= e_mem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h_mem[h_waddr] <= h_wdata;
    end
    h_rd_q <= h_mem[h_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (coef_wr && (sel_q == SEL_H_SELF)) begin
      hs_mem[node_addr] <= coef_q;
    end
    hs_rd_q <= hs_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (coef_wr && (sel_q == SEL_H_CURL)) begin
      hc_mem[node_addr] <= coef_q;
    end
    hc_rd_q <= hc_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (coef_wr && (sel_q == SEL_E_SELF)) begin
      es_mem[node_addr] <= coef_q;
    end
    es_rd_q <= es_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (coef_wr && (sel_q == SEL_E_CURL)) begin
      ec_mem[node_addr] <= coef_q;
    end
    ec_rd_q <= ec_mem[idx_q];
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `FD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `FD_ASSERT_NOW(a_mul_shared, pv_q[0], !pv_q[1], "two nodes on the multiplier at once")
  `FD_ASSERT_NOW(a_done_after_work, done_o, $past(busy), "result strobe with no request")
  `FD_ASSERT_NOW(a_fin_drained, state_q == S_FIN, pv_q == 4'b0000, "step ended with nodes in flight")

endmodule
